FILE: rtl/slab_bitmap_object_allocator_core_macros.svh
// Assertion macros shared by the slab allocator RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef SLAB_BITMAP_OBJECT_ALLOCATOR_CORE_MACROS_SVH
`define SLAB_BITMAP_OBJECT_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while in reset
`define SBOA_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("sboa check failed");
// next-cycle implication, disabled while in reset
`define SBOA_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("sboa check failed");
`else
`define SBOA_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define SBOA_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

FILE: rtl/sboa_pkg.sv
// Shared constants and types for the slab bitmap object allocator.
// No dependencies; used by sboa_bit_search and the top level.
`timescale 1ns / 1ps

package sboa_pkg;

    localparam int MAX_PAGES      = 16;
    localparam int SLOTS_PER_PAGE = 64;

    localparam int PAGE_W = $clog2(MAX_PAGES);
    localparam int PIU_W  = $clog2(MAX_PAGES + 1);
    localparam int SLOT_W = $clog2(SLOTS_PER_PAGE);
    localparam int CNT_W  = $clog2(SLOTS_PER_PAGE + 1);

    // field widths fixed by the interface
    localparam int OPP_W    = 7;
    localparam int OBJ_W    = 11;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 1;

    // first-clear search: one chunk of the row per cycle
    localparam int CHUNK_W  = 8;
    localparam int CHUNKS   = SLOTS_PER_PAGE / CHUNK_W;
    localparam int CHUNK_IW = $clog2(CHUNKS);
    localparam int BIT_IW   = $clog2(CHUNK_W);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LIMIT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_PAGE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_OBJECTS_PER_PAGE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_OBJECTS      = 1'd1;

    typedef struct packed {
        logic              done;
        logic              found;
        logic [SLOT_W-1:0] index;
    } sboa_search_t;

endpackage

FILE: rtl/sboa_bit_search.sv
// Iterative first-clear-bit search over one page bitmap, a chunk per cycle.
// Depends on sboa_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`include "slab_bitmap_object_allocator_core_macros.svh"

module sboa_bit_search (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [sboa_pkg::SLOTS_PER_PAGE-1:0]   row,
    output sboa_pkg::sboa_search_t                result
);

    logic                          active_reg;
    logic [sboa_pkg::CHUNK_IW-1:0] chunk_reg;
    sboa_pkg::sboa_search_t        result_reg;
    logic [sboa_pkg::CHUNK_W-1:0]  chunk_bits;
    logic                          hit;
    logic [sboa_pkg::BIT_IW-1:0]   bit_idx;
    logic                          last_chunk;

    assign chunk_bits = row[chunk_reg * sboa_pkg::CHUNK_W +: sboa_pkg::CHUNK_W];
    assign last_chunk = (chunk_reg == sboa_pkg::CHUNK_IW'(sboa_pkg::CHUNKS - 1));

    always_comb
    begin
        hit     = 1'b0;
        bit_idx = '0;
        for (int i = 0; i < sboa_pkg::CHUNK_W; i++)
        begin
            if (!hit && !chunk_bits[i])
            begin
                hit     = 1'b1;
                bit_idx = sboa_pkg::BIT_IW'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= 1'b0;
            chunk_reg        <= '0;
            result_reg.done  <= 1'b0;
            result_reg.found <= 1'b0;
            result_reg.index <= '0;
        end
        else
        begin
            if (start)
            begin
                active_reg      <= 1'b1;
                chunk_reg       <= '0;
                result_reg.done <= 1'b0;
            end
            else if (active_reg && (hit || last_chunk))
            begin
                // stop at the first clear bit or after the last chunk
                active_reg       <= 1'b0;
                result_reg.done  <= 1'b1;
                result_reg.found <= hit;
                result_reg.index <= {chunk_reg, bit_idx};
            end
            else
            begin
                result_reg.done <= 1'b0;
                if (active_reg)
                    chunk_reg <= chunk_reg + 1'b1;
            end
        end
    end

    assign result = result_reg;

    `SBOA_ASSERT_NXT(a_hit_reports, clk, rst_n, active_reg && !start && hit, result_reg.done && result_reg.found)
    `SBOA_ASSERT_IMP(a_done_idle, clk, rst_n, result_reg.done, !active_reg)
    `SBOA_ASSERT_IMP(a_start_idle, clk, rst_n, start, !active_reg)

endmodule

FILE: rtl/slab_bitmap_object_allocator_core.sv
// Slab bitmap object allocator: one command at a time through a small sequencer.
// Free and refused allocate go straight to the response state; allocate runs hint, test
// and commit, scanning pages (up to 16) when the hint page is empty, searching if the slot is busy.
// Next command is taken the cycle after the result word is registered.
// Reset (async, low): counts, page count and hint cleared, config to 64 / 1024.
// Page bitmaps are rebuilt when a page is added and need no clearing pass.
`timescale 1ns / 1ps
`include "slab_bitmap_object_allocator_core_macros.svh"

module slab_bitmap_object_allocator_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sboa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sboa_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                cmd,
    input  logic [sboa_pkg::PAGE_W-1:0]         free_page,
    input  logic [sboa_pkg::SLOT_W-1:0]         free_slot,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [sboa_pkg::STATUS_W-1:0]       status,
    output logic [sboa_pkg::PAGE_W-1:0]         out_page,
    output logic [sboa_pkg::SLOT_W-1:0]         out_slot,
    output logic                                needs_construct
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_FREE   = 9'b000000010,
        S_ALLOC  = 9'b000000100,
        S_HINT   = 9'b000001000,
        S_SCAN   = 9'b000010000,
        S_TEST   = 9'b000100000,
        S_SEARCH = 9'b001000000,
        S_COMMIT = 9'b010000000,
        S_RESP   = 9'b100000000
    } state_t;

    typedef logic [sboa_pkg::SLOTS_PER_PAGE-1:0] row_t;

    state_t state_reg, state_next;

    // configuration and scalar allocator state
    logic [sboa_pkg::OPP_W-1:0]  opp_reg;
    logic [sboa_pkg::OBJ_W-1:0]  max_reg;
    logic [sboa_pkg::OBJ_W-1:0]  cache_reg;
    logic [sboa_pkg::OBJ_W-1:0]  total_reg;
    logic [sboa_pkg::PIU_W-1:0]  piu_reg;
    logic [sboa_pkg::PAGE_W-1:0] hint_page_reg;
    logic                        hint_valid_reg;

    // per-page storage
    row_t                       alloc_bm_reg [sboa_pkg::MAX_PAGES];
    row_t                       cons_bm_reg  [sboa_pkg::MAX_PAGES];
    logic [sboa_pkg::CNT_W-1:0] cnt_reg      [sboa_pkg::MAX_PAGES];
    logic [sboa_pkg::CNT_W-1:0] cap_reg      [sboa_pkg::MAX_PAGES];

    // command and working registers
    logic                          cmd_reg;
    logic [sboa_pkg::PAGE_W-1:0]   fpage_reg;
    logic [sboa_pkg::SLOT_W-1:0]   fslot_reg;
    logic [sboa_pkg::PAGE_W-1:0]   page_reg;
    logic [sboa_pkg::SLOT_W-1:0]   slot_reg;
    logic [sboa_pkg::PIU_W-1:0]    scan_reg;

    logic [sboa_pkg::STATUS_W-1:0] res_status_reg;
    logic [sboa_pkg::PAGE_W-1:0]   res_page_reg;
    logic [sboa_pkg::SLOT_W-1:0]   res_slot_reg;
    logic                          res_nc_reg;

    logic                          out_valid_reg;
    logic [sboa_pkg::STATUS_W-1:0] out_status_reg;
    logic [sboa_pkg::PAGE_W-1:0]   out_page_reg;
    logic [sboa_pkg::SLOT_W-1:0]   out_slot_reg;
    logic                          out_nc_reg;

    // single read port into the page storage
    logic [sboa_pkg::PAGE_W-1:0] rd_page;
    row_t                        rd_alloc;
    row_t                        rd_cons;
    logic [sboa_pkg::CNT_W-1:0]  rd_cnt;
    logic [sboa_pkg::CNT_W-1:0]  rd_cap;
    logic [sboa_pkg::SLOT_W-1:0] rd_obj;

    logic                        free_bad;
    logic                        lim_hit;
    logic                        pages_full;
    logic                        grow;
    logic                        hint_hit;
    logic                        scan_in;
    logic                        scan_hit;
    logic                        take_ok;
    logic                        srch_start;
    sboa_pkg::sboa_search_t      srch;

    logic [sboa_pkg::CNT_W-1:0]  cap_clamp;
    logic [sboa_pkg::OBJ_W-1:0]  room;
    logic [sboa_pkg::CNT_W-1:0]  grow_cap;
    row_t                        grow_mask;
    logic [sboa_pkg::PAGE_W-1:0] grow_page;

    always_comb
    begin
        unique case (state_reg)
            S_FREE:  rd_page = fpage_reg;
            S_HINT:  rd_page = hint_page_reg;
            S_SCAN:  rd_page = scan_reg[sboa_pkg::PAGE_W-1:0];
            default: rd_page = page_reg;
        endcase
    end

    assign rd_alloc = alloc_bm_reg[rd_page];
    assign rd_cons  = cons_bm_reg[rd_page];
    assign rd_cnt   = cnt_reg[rd_page];
    assign rd_cap   = cap_reg[rd_page];
    assign rd_obj   = sboa_pkg::SLOT_W'(rd_cnt - 1'b1);

    assign free_bad = ({1'b0, fpage_reg} >= piu_reg)
                   || (sboa_pkg::CNT_W'(fslot_reg) >= rd_cap)
                   || (rd_cnt >= rd_cap)
                   || !rd_alloc[fslot_reg];

    assign lim_hit    = (total_reg >= max_reg);
    assign pages_full = (piu_reg >= sboa_pkg::PIU_W'(sboa_pkg::MAX_PAGES));
    assign grow       = (state_reg == S_ALLOC) && (cache_reg == '0) && !lim_hit && !pages_full;
    assign hint_hit   = hint_valid_reg && ({1'b0, hint_page_reg} < piu_reg) && (rd_cnt != '0);
    assign scan_in    = (scan_reg < piu_reg);
    assign scan_hit   = scan_in && (rd_cnt != '0);
    assign take_ok    = !out_valid_reg || !out_stall;
    assign srch_start = (state_reg == S_TEST) && rd_alloc[slot_reg];

    // capacity of a new page: clamp the register, then limit to the room left
    always_comb
    begin
        if (opp_reg == '0)
            cap_clamp = sboa_pkg::CNT_W'(1);
        else if (opp_reg > sboa_pkg::OPP_W'(sboa_pkg::SLOTS_PER_PAGE))
            cap_clamp = sboa_pkg::CNT_W'(sboa_pkg::SLOTS_PER_PAGE);
        else
            cap_clamp = sboa_pkg::CNT_W'(opp_reg);
        room = max_reg - total_reg;
        if (sboa_pkg::OBJ_W'(cap_clamp) > room)
            grow_cap = room[sboa_pkg::CNT_W-1:0];
        else
            grow_cap = cap_clamp;
        for (int i = 0; i < sboa_pkg::SLOTS_PER_PAGE; i++)
            grow_mask[i] = (sboa_pkg::CNT_W'(i) >= grow_cap);
    end

    assign grow_page = piu_reg[sboa_pkg::PAGE_W-1:0];

    sboa_bit_search u_search (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (srch_start),
        .row    (rd_alloc),
        .result (srch)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = (cmd == sboa_pkg::CMD_FREE) ? S_FREE : S_ALLOC;
            end
            S_FREE:
                state_next = S_RESP;
            S_ALLOC:
            begin
                if (cache_reg == '0 && (lim_hit || pages_full))
                    state_next = S_RESP;
                else
                    state_next = S_HINT;
            end
            S_HINT:
                state_next = hint_hit ? S_TEST : S_SCAN;
            S_SCAN:
            begin
                if (!scan_in)
                    state_next = S_RESP;
                else if (scan_hit)
                    state_next = S_TEST;
            end
            S_TEST:
                state_next = rd_alloc[slot_reg] ? S_SEARCH : S_COMMIT;
            S_SEARCH:
            begin
                if (srch.done)
                    state_next = srch.found ? S_COMMIT : S_RESP;
            end
            S_COMMIT:
                state_next = S_RESP;
            S_RESP:
            begin
                if (take_ok)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            opp_reg        <= sboa_pkg::OPP_W'(64);
            max_reg        <= sboa_pkg::OBJ_W'(1024);
            cache_reg      <= '0;
            total_reg      <= '0;
            piu_reg        <= '0;
            hint_page_reg  <= '0;
            hint_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    sboa_pkg::CFG_OBJECTS_PER_PAGE: opp_reg <= cfg_data[sboa_pkg::OPP_W-1:0];
                    sboa_pkg::CFG_MAX_OBJECTS:      max_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (state_reg == S_FREE && !free_bad)
                cache_reg <= cache_reg + 1'b1;

            if (grow)
            begin
                piu_reg        <= piu_reg + 1'b1;
                cache_reg      <= cache_reg + sboa_pkg::OBJ_W'(grow_cap);
                total_reg      <= total_reg + sboa_pkg::OBJ_W'(grow_cap);
                hint_page_reg  <= grow_page;
                hint_valid_reg <= 1'b1;
            end

            // a page found by the scan with more than one free slot becomes the hint
            if (state_reg == S_SCAN && scan_hit && rd_cnt > sboa_pkg::CNT_W'(1))
            begin
                hint_page_reg  <= scan_reg[sboa_pkg::PAGE_W-1:0];
                hint_valid_reg <= 1'b1;
            end

            if (state_reg == S_COMMIT)
                cache_reg <= cache_reg - 1'b1;

            if (state_reg == S_RESP && take_ok)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // page storage and datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_reg   <= cmd;
                    fpage_reg <= free_page;
                    fslot_reg <= free_slot;
                end
            end
            S_FREE:
            begin
                res_page_reg <= fpage_reg;
                res_slot_reg <= fslot_reg;
                res_nc_reg   <= 1'b0;
                if (free_bad)
                    res_status_reg <= sboa_pkg::ST_BAD_FREE;
                else
                begin
                    res_status_reg                  <= sboa_pkg::ST_OK;
                    alloc_bm_reg[fpage_reg][fslot_reg] <= 1'b0;
                    cnt_reg[fpage_reg]              <= rd_cnt + 1'b1;
                end
            end
            S_ALLOC:
            begin
                res_page_reg   <= '0;
                res_slot_reg   <= '0;
                res_nc_reg     <= 1'b0;
                res_status_reg <= lim_hit ? sboa_pkg::ST_LIMIT : sboa_pkg::ST_NO_PAGE;
                if (grow)
                begin
                    alloc_bm_reg[grow_page] <= grow_mask;
                    cons_bm_reg[grow_page]  <= '0;
                    cnt_reg[grow_page]      <= grow_cap;
                    cap_reg[grow_page]      <= grow_cap;
                end
            end
            S_HINT:
            begin
                page_reg <= hint_page_reg;
                slot_reg <= rd_obj;
                scan_reg <= '0;
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    page_reg <= scan_reg[sboa_pkg::PAGE_W-1:0];
                    slot_reg <= rd_obj;
                end
                else
                    scan_reg <= scan_reg + 1'b1;
            end
            S_TEST: ;
            S_SEARCH:
            begin
                if (srch.done && srch.found)
                    slot_reg <= srch.index;
            end
            S_COMMIT:
            begin
                alloc_bm_reg[page_reg][slot_reg] <= 1'b1;
                cons_bm_reg[page_reg][slot_reg]  <= 1'b1;
                cnt_reg[page_reg]                <= rd_cnt - 1'b1;
                res_status_reg                   <= sboa_pkg::ST_OK;
                res_page_reg                     <= page_reg;
                res_slot_reg                     <= slot_reg;
                res_nc_reg                       <= !rd_cons[slot_reg];
            end
            S_RESP:
            begin
                if (take_ok)
                begin
                    out_status_reg <= res_status_reg;
                    out_page_reg   <= res_page_reg;
                    out_slot_reg   <= res_slot_reg;
                    out_nc_reg     <= res_nc_reg;
                end
            end
            default: ;
        endcase
    end

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign out_page        = out_page_reg;
    assign out_slot        = out_slot_reg;
    assign needs_construct = out_nc_reg;

    `SBOA_ASSERT_IMP(a_cache_le_total, clk, rst_n, 1'b1, cache_reg <= total_reg)
    `SBOA_ASSERT_IMP(a_pages_bound, clk, rst_n, 1'b1, piu_reg <= sboa_pkg::PIU_W'(sboa_pkg::MAX_PAGES))
    `SBOA_ASSERT_IMP(a_commit_clear, clk, rst_n, state_reg == S_COMMIT, !rd_alloc[slot_reg] && cmd_reg == sboa_pkg::CMD_ALLOC)
    `SBOA_ASSERT_NXT(a_resp_loads, clk, rst_n, state_reg == S_RESP && take_ok, out_valid_reg && state_reg == S_IDLE)

endmodule

FILE: sim/tb_slab_bitmap_object_allocator_core.sv
// Self-checking testbench for slab_bitmap_object_allocator_core.
// Drives alloc/free words against an in-bench slab predictor; depends on sboa_pkg
// and the core RTL only.
`timescale 1ns / 1ps

module tb_slab_bitmap_object_allocator_core;

    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [sboa_pkg::STATUS_W-1:0] status;
        logic [sboa_pkg::PAGE_W-1:0]   page;
        logic [sboa_pkg::SLOT_W-1:0]   slot;
        logic                          fresh;
    } alloc_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we;
    logic [sboa_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [sboa_pkg::CFG_W-1:0]     cfg_data;
    logic                           in_valid;
    logic                           in_stall;
    logic                           cmd;
    logic [sboa_pkg::PAGE_W-1:0]    free_page;
    logic [sboa_pkg::SLOT_W-1:0]    free_slot;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [sboa_pkg::STATUS_W-1:0]  status;
    logic [sboa_pkg::PAGE_W-1:0]    out_page;
    logic [sboa_pkg::SLOT_W-1:0]    out_slot;
    logic                           needs_construct;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;

    alloc_result_t expected_q [$];

    // slab state as the allocator should hold it
    logic [sboa_pkg::SLOTS_PER_PAGE-1:0] busy_map [sboa_pkg::MAX_PAGES];
    logic [sboa_pkg::SLOTS_PER_PAGE-1:0] built_map [sboa_pkg::MAX_PAGES];
    int unsigned free_cnt [sboa_pkg::MAX_PAGES];
    int unsigned cap_of [sboa_pkg::MAX_PAGES];
    int unsigned pool_free, obj_total, pages_used, hint_pg;
    bit          hint_ok;
    int unsigned opp_reg, max_reg;

    slab_bitmap_object_allocator_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .free_page       (free_page),
        .free_slot       (free_slot),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .out_page        (out_page),
        .out_slot        (out_slot),
        .needs_construct (needs_construct)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin : check_results
        alloc_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                err_count++;
                $error("result word with nothing expected: status %0d page %0d slot %0d",
                       status, out_page, out_slot);
            end
            else
            begin
                want = expected_q.pop_front();
                if (status !== want.status)
                begin
                    err_count++;
                    $error("status: expected %0d, got %0d", want.status, status);
                end
                if (out_page !== want.page)
                begin
                    err_count++;
                    $error("out_page: expected %0d, got %0d", want.page, out_page);
                end
                if (out_slot !== want.slot)
                begin
                    err_count++;
                    $error("out_slot: expected %0d, got %0d", want.slot, out_slot);
                end
                if (needs_construct !== want.fresh)
                begin
                    err_count++;
                    $error("needs_construct: expected %0d, got %0d",
                           want.fresh, needs_construct);
                end
            end
        end
    end

    function automatic int take_slot(int unsigned p);
        take_slot = -1;
        if (free_cnt[p] != 0)
        begin
            free_cnt[p]--;
            take_slot = free_cnt[p];
        end
    endfunction

    task automatic predict_word(input logic c, input logic [sboa_pkg::PAGE_W-1:0] pg,
                                input logic [sboa_pkg::SLOT_W-1:0] sl);
        alloc_result_t res;
        int            taken;
        int unsigned   pick, cap;
        res = '0;
        if (c == sboa_pkg::CMD_FREE)
        begin
            res.page = pg;
            res.slot = sl;
            if (pg >= pages_used || sl >= cap_of[pg] || free_cnt[pg] >= cap_of[pg]
                || !busy_map[pg][sl])
                res.status = sboa_pkg::ST_BAD_FREE;
            else
            begin
                busy_map[pg][sl] = 1'b0;
                free_cnt[pg]++;
                pool_free++;
            end
        end
        else if (pool_free == 0 && obj_total >= max_reg)
            res.status = sboa_pkg::ST_LIMIT;
        else if (pool_free == 0 && pages_used >= sboa_pkg::MAX_PAGES)
            res.status = sboa_pkg::ST_NO_PAGE;
        else
        begin
            if (pool_free == 0)
            begin
                // grow by one page, clamp its size, mark the unused tail busy
                cap = (opp_reg == 0) ? 1 : opp_reg;
                if (cap > sboa_pkg::SLOTS_PER_PAGE)
                    cap = sboa_pkg::SLOTS_PER_PAGE;
                if (cap > max_reg - obj_total)
                    cap = max_reg - obj_total;
                busy_map[pages_used]  = {sboa_pkg::SLOTS_PER_PAGE{1'b1}} << cap;
                built_map[pages_used] = '0;
                free_cnt[pages_used]  = cap;
                cap_of[pages_used]    = cap;
                hint_pg    = pages_used;
                hint_ok    = 1'b1;
                pages_used = pages_used + 1;
                pool_free += cap;
                obj_total += cap;
            end
            pool_free--;
            taken = -1;
            pick  = 0;
            if (hint_ok && hint_pg < pages_used)
            begin
                pick  = hint_pg;
                taken = take_slot(pick);
            end
            for (int p = 0; p < pages_used; p++)
                if (taken < 0)
                begin
                    taken = take_slot(p);
                    if (taken >= 0)
                    begin
                        pick = p;
                        if (taken > 0)
                        begin
                            hint_pg = p;
                            hint_ok = 1'b1;
                        end
                    end
                end
            if (taken < 0)
            begin
                pool_free++;
                res.status = sboa_pkg::ST_NO_PAGE;
            end
            else
            begin
                if (busy_map[pick][taken])
                begin
                    taken = -1;
                    for (int s = 0; s < sboa_pkg::SLOTS_PER_PAGE; s++)
                        if (taken < 0 && !busy_map[pick][s])
                            taken = s;
                end
                if (taken < 0)
                begin
                    free_cnt[pick]++;
                    pool_free++;
                    res.status = sboa_pkg::ST_NO_PAGE;
                end
                else
                begin
                    busy_map[pick][taken] = 1'b1;
                    res.status = sboa_pkg::ST_OK;
                    res.page   = pick[sboa_pkg::PAGE_W-1:0];
                    res.slot   = taken[sboa_pkg::SLOT_W-1:0];
                    res.fresh  = !built_map[pick][taken];
                    built_map[pick][taken] = 1'b1;
                end
            end
        end
        expected_q.push_back(res);
    endtask

    // drive one word, hold it until taken, then record what it should produce
    task automatic send_word(input logic c, input logic [sboa_pkg::PAGE_W-1:0] pg,
                             input logic [sboa_pkg::SLOT_W-1:0] sl);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        free_page <= pg;
        free_slot <= sl;
        do
            @(posedge clk);
        while (in_stall);
        predict_word(c, pg, sl);
    endtask

    // drop valid and wait until every expected word has come back
    task automatic settle(input int hold);
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (hold) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sboa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sboa_pkg::CFG_W-1:0] val);
        settle(SETTLE_CYCLES);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == sboa_pkg::CFG_OBJECTS_PER_PAGE)
            opp_reg = val & 'h7F;
        else
            max_reg = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // pick a slot that a free would release cleanly
    function automatic bit pick_live(output logic [sboa_pkg::PAGE_W-1:0] pg,
                                     output logic [sboa_pkg::SLOT_W-1:0] sl);
        int unsigned live [$];
        int unsigned code;
        for (int p = 0; p < pages_used; p++)
            if (free_cnt[p] < cap_of[p])
                for (int s = 0; s < cap_of[p]; s++)
                    if (busy_map[p][s])
                        live.push_back(p * sboa_pkg::SLOTS_PER_PAGE + s);
        pg = '0;
        sl = '0;
        pick_live = (live.size() != 0);
        if (pick_live)
        begin
            code = live[$urandom_range(live.size() - 1)];
            pg   = sboa_pkg::PAGE_W'(code / sboa_pkg::SLOTS_PER_PAGE);
            sl   = sboa_pkg::SLOT_W'(code % sboa_pkg::SLOTS_PER_PAGE);
        end
    endfunction

    task automatic random_words(input int count, input int alloc_pct, input int free_pct);
        logic [sboa_pkg::PAGE_W-1:0] pg;
        logic [sboa_pkg::SLOT_W-1:0] sl;
        int unsigned                 roll;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(39) == 0)
                settle(0);
            roll = $urandom_range(99);
            if (roll < alloc_pct)
                send_word(sboa_pkg::CMD_ALLOC, sboa_pkg::PAGE_W'($urandom_range(15)),
                          sboa_pkg::SLOT_W'($urandom_range(63)));
            else if (roll < alloc_pct + free_pct && pick_live(pg, sl))
                send_word(sboa_pkg::CMD_FREE, pg, sl);
            else
                send_word(sboa_pkg::CMD_FREE, sboa_pkg::PAGE_W'($urandom_range(15)),
                          sboa_pkg::SLOT_W'($urandom_range(63)));
        end
    endtask

    task automatic test_bad_frees();
        send_word(sboa_pkg::CMD_FREE, 4'd0, 6'd0);
        send_word(sboa_pkg::CMD_FREE, 4'd15, 6'd63);
    endtask

    task automatic test_tiny_pages();
        // zero per page behaves as one
        write_reg(sboa_pkg::CFG_OBJECTS_PER_PAGE, 11'd0);
        send_word(sboa_pkg::CMD_ALLOC, 4'd15, 6'd63);
        send_word(sboa_pkg::CMD_FREE, 4'd0, 6'd0);
        send_word(sboa_pkg::CMD_FREE, 4'd0, 6'd0);
        send_word(sboa_pkg::CMD_ALLOC, 4'd0, 6'd0);
        send_word(sboa_pkg::CMD_FREE, 4'd0, 6'd1);
        write_reg(sboa_pkg::CFG_OBJECTS_PER_PAGE, 11'd3);
        send_word(sboa_pkg::CMD_ALLOC, 4'd0, 6'd0);
        send_word(sboa_pkg::CMD_ALLOC, 4'd0, 6'd0);
        send_word(sboa_pkg::CMD_FREE, 4'd1, 6'd2);
        send_word(sboa_pkg::CMD_FREE, 4'd1, 6'd0);
        // next two land on busy slots and fall back to the first clear bit
        send_word(sboa_pkg::CMD_ALLOC, 4'd0, 6'd0);
        send_word(sboa_pkg::CMD_ALLOC, 4'd0, 6'd0);
    endtask

    task automatic test_capacity_limits();
        write_reg(sboa_pkg::CFG_MAX_OBJECTS, 11'd0);
        send_word(sboa_pkg::CMD_ALLOC, 4'd0, 6'd0);
        // room for two more only: the new page is cut short
        write_reg(sboa_pkg::CFG_MAX_OBJECTS, 11'd6);
        send_word(sboa_pkg::CMD_ALLOC, 4'd0, 6'd0);
        send_word(sboa_pkg::CMD_ALLOC, 4'd0, 6'd0);
        send_word(sboa_pkg::CMD_ALLOC, 4'd0, 6'd0);
    endtask

    task automatic test_full_pages();
        // upper bits dropped, 127 clamps to a full page
        write_reg(sboa_pkg::CFG_OBJECTS_PER_PAGE, 11'h47F);
        write_reg(sboa_pkg::CFG_MAX_OBJECTS, 11'd1024);
        send_word(sboa_pkg::CMD_ALLOC, 4'd0, 6'd0);
        send_word(sboa_pkg::CMD_FREE, 4'd3, 6'd63);
        send_word(sboa_pkg::CMD_ALLOC, 4'd0, 6'd0);
        send_word(sboa_pkg::CMD_FREE, 4'd3, 6'd62);
    endtask

    task automatic test_random_slow_receiver();
        write_reg(sboa_pkg::CFG_OBJECTS_PER_PAGE, sboa_pkg::CFG_W'($urandom_range(12, 5)));
        send_idle_pct = 24;
        recv_idle_pct = 46;
        random_words(250, 60, 30);
    endtask

    task automatic test_random_slow_sender();
        write_reg(sboa_pkg::CFG_OBJECTS_PER_PAGE, 11'h440);
        send_idle_pct = 46;
        recv_idle_pct = 24;
        random_words(250, 50, 40);
    endtask

    task automatic test_random_exhaustion();
        write_reg(sboa_pkg::CFG_OBJECTS_PER_PAGE, sboa_pkg::CFG_W'($urandom_range(4, 1)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // run out of pages, then pin the limit at the current total
        random_words(150, 75, 15);
        write_reg(sboa_pkg::CFG_MAX_OBJECTS, sboa_pkg::CFG_W'(obj_total));
        random_words(100, 60, 30);
    endtask

    initial
    begin
        in_valid  = 1'b0;
        cmd       = sboa_pkg::CMD_ALLOC;
        free_page = '0;
        free_slot = '0;
        cfg_we    = 1'b0;
        cfg_index = sboa_pkg::CFG_OBJECTS_PER_PAGE;
        cfg_data  = '0;
        for (int p = 0; p < sboa_pkg::MAX_PAGES; p++)
        begin
            busy_map[p]  = '0;
            built_map[p] = '0;
            free_cnt[p]  = 0;
            cap_of[p]    = 0;
        end
        pool_free  = 0;
        obj_total  = 0;
        pages_used = 0;
        hint_pg    = 0;
        hint_ok    = 1'b0;
        opp_reg    = 64;
        max_reg    = 1024;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_bad_frees();
        test_tiny_pages();
        test_capacity_limits();
        test_full_pages();
        test_random_slow_receiver();
        test_random_slow_sender();
        test_random_exhaustion();

        settle(SETTLE_CYCLES);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
